// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ICAF_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("icaf check failed");

// next-cycle implication
`define ICAF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("icaf check failed");

`endif

// ===== rtl/icaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package icaf_pkg;

	localparam int CALIB_SAMPLES   = 1024;
	localparam int TEMP_FRAC_BITS  = 16;
	localparam int ANGLE_FRAC_BITS = 16;

	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_FRAC  = 24;
	localparam int ROT_SHIFT    = CORDIC_FRAC - ANGLE_FRAC_BITS;
	localparam int GYRO_SHIFT   = 32 - ANGLE_FRAC_BITS;
	localparam longint ROT_RND  = (ROT_SHIFT == 0) ? 0 : (longint'(1) << (ROT_SHIFT - 1));
	localparam longint GYRO_RND = longint'(1) << (GYRO_SHIFT - 1);
	localparam longint HALF_TURN = longint'(180) << CORDIC_FRAC;

	// calibration offsets: sum over a power-of-two count, shifted down
	localparam int CAL_SHIFT = $clog2(CALIB_SAMPLES);

	localparam int RATE_SHIFT = 17;
	localparam int RATE_DIVISOR = 131;
	localparam int TEMP_DIVISOR = 340;
	localparam int TEMP_BIAS    = 12412;
	localparam int ONE_G        = 65536;
	localparam int WEIGHT_ONE   = 65536;

	// rate scale 2^17/131 = whole part plus remainder/131, the latter by reciprocal
	localparam int RATE_INT   = (1 << RATE_SHIFT) / RATE_DIVISOR;
	localparam int RATE_REM   = (1 << RATE_SHIFT) % RATE_DIVISOR;
	localparam int RATE_REM_W = 23;
	localparam int RATE_K     = RATE_REM_W + $clog2(RATE_DIVISOR);
	localparam longint RATE_RECIP =
		((longint'(1) << RATE_K) + RATE_DIVISOR - 1) / RATE_DIVISOR;
	localparam int RATE_RCP_W = RATE_K - $clog2(RATE_DIVISOR) + 1;
	localparam int RATE_PRD_W = RATE_REM_W + RATE_RCP_W;

	// temperature scale: 340 = 4 * 85, drop the 4 then reciprocal of 85
	localparam int TDIV_NUM_W     = 32;
	localparam int TEMP_PRE_SHIFT = 2;
	localparam int TDIV_PRE_W     = TDIV_NUM_W - TEMP_PRE_SHIFT;
	localparam int TEMP_ODD       = TEMP_DIVISOR >> TEMP_PRE_SHIFT;
	localparam int TEMP_K         = TDIV_PRE_W + $clog2(TEMP_ODD);
	localparam longint TEMP_RECIP = ((longint'(1) << TEMP_K) + TEMP_ODD - 1) / TEMP_ODD;
	localparam int TDIV_RCP_W     = TEMP_K - $clog2(TEMP_ODD) + 1;
	localparam int TDIV_PRD_W     = TDIV_PRE_W + TDIV_RCP_W;
	localparam int TDIV_QUO_W     = 24;

	localparam int SQRT_W     = 40;
	localparam int SQRT_STEPS = 20;
	localparam int STEP_W     = $clog2(CORDIC_STEPS);
	localparam int CW         = 24;
	localparam int ZW         = 36;

	localparam logic [29:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938, 30'd60000934,
		30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
		30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671,
		30'd29335, 30'd14668, 30'd7334, 30'd3667, 30'd1833
	};

	typedef logic signed [15:0] raw_t;
	typedef raw_t [2:0] raw3_t;
	typedef logic signed [19:0] accg_t;
	typedef logic signed [26:0] rate_t;
	typedef logic signed [24:0] temp_t;
	typedef logic signed [31:0] ang_t;
	typedef logic signed [32:0] ang_wide_t;

	typedef enum logic [1:0] {CFG_MAP_X, CFG_MAP_Y, CFG_MAP_Z, CFG_WEIGHT} cfg_idx_t;
	typedef enum logic [0:0] {OP_CAL, OP_UPDATE} op_t;

	typedef enum logic [2:0] {
		TP_IDLE, TP_SQ, TP_SQRT, TP_ROT_INIT, TP_ROT, TP_ROUND
	} tilt_st_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CAL, ST_WORK, ST_SMOOTH, ST_DIFF, ST_MUL, ST_BLEND, ST_OUT
	} top_st_t;

endpackage
`default_nettype wire

// ===== rtl/icaf_sdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// divide by the temperature scale: shift out the power of two, then multiply by
// the rounded-up reciprocal of the odd part; exact over the whole numerator range
module icaf_sdiv (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [icaf_pkg::TDIV_NUM_W-1:0] numer,
	output logic                                 done,
	output logic [icaf_pkg::TDIV_QUO_W-1:0]      quot
);
	import icaf_pkg::*;

	logic                  v_s1;
	logic                  v_s2;
	logic [TDIV_PRE_W-1:0] n_s1;
	logic [TDIV_PRD_W-1:0] prod;
	logic [TDIV_QUO_W-1:0] q_s2;

	always_comb begin
		prod = TDIV_PRD_W'(n_s1) * TDIV_PRD_W'(TEMP_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			n_s1 <= TDIV_PRE_W'(numer >> TEMP_PRE_SHIFT);
		if (v_s1)
			q_s2 <= TDIV_QUO_W'(prod >> TEMP_K);
	end

	assign done = v_s2;
	assign quot = q_s2;
endmodule
`default_nettype wire

// ===== rtl/icaf_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// one drone axis: remap, offset removal, scaling, gyro integration
module icaf_axis (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [2:0]         axis_map,
	input  wire icaf_pkg::raw3_t           acc_raw,
	input  wire icaf_pkg::raw3_t           rate_raw,
	input  wire icaf_pkg::raw3_t           acc_off,
	input  wire icaf_pkg::raw3_t           rate_off,
	input  wire logic [15:0]               time_step,
	input  wire icaf_pkg::ang_t            ang_old,
	output icaf_pkg::accg_t                acc_g,
	output icaf_pkg::rate_t                rate_dps,
	output icaf_pkg::ang_wide_t            ang_new,
	output logic                           done
);
	import icaf_pkg::*;

	logic               en;
	logic               neg;
	logic [2:0]         mag;
	logic [1:0]         idx;
	logic signed [16:0] da;
	logic signed [16:0] dr;
	logic signed [17:0] sa;
	logic signed [17:0] sr;
	logic [16:0]        rmag;

	logic                  go_s1;
	logic                  rneg_s1;
	logic [16:0]           rmag_s1;
	accg_t                 acc_s1;
	logic                  v_s2;
	logic [26:0]           base_s2;
	logic [RATE_REM_W-1:0] rem_s2;
	logic [RATE_PRD_W-1:0] frac_prod;
	logic                  v_s3;
	logic [26:0]           base_s3;
	logic [26:0]           frac_s3;
	logic [26:0]           rsum;
	logic                  v_s4;
	rate_t                 rate_s4;
	logic                  v_s5;
	logic signed [43:0]    prod_s5;
	logic signed [43:0]    prod_rnd;
	ang_wide_t             ang_q;
	logic                  done_q;

	always_comb begin
		en   = (axis_map != 3'sd0) && (axis_map != -3'sd4);
		neg  = axis_map[2];
		mag  = neg ? 3'(-axis_map) : 3'(axis_map);
		idx  = mag[1:0] - 2'd1;
		da   = $signed({acc_raw[idx][15], acc_raw[idx]}) - $signed({acc_off[idx][15], acc_off[idx]});
		dr   = $signed({rate_raw[idx][15], rate_raw[idx]}) -
			$signed({rate_off[idx][15], rate_off[idx]});
		sa   = en ? (neg ? -18'(da) : 18'(da)) : '0;
		sr   = en ? (neg ? -18'(dr) : 18'(dr)) : '0;
		rmag = sr[17] ? 17'(-sr) : 17'(sr);
		// remainder part of the rate scale, floor division by reciprocal
		frac_prod = RATE_PRD_W'(rem_s2) * RATE_PRD_W'(RATE_RECIP);
		rsum      = base_s3 + frac_s3;
		prod_rnd  = prod_s5 + 44'(GYRO_RND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1  <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_s1  <= start;
			v_s2   <= go_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_s1  <= {sa, 2'b00};
			rneg_s1 <= sr[17];
			rmag_s1 <= rmag;
		end
		if (go_s1) begin
			base_s2 <= 27'(rmag_s1) * 27'(RATE_INT);
			rem_s2  <= RATE_REM_W'(rmag_s1) * RATE_REM_W'(RATE_REM);
		end
		if (v_s2) begin
			base_s3 <= base_s2;
			frac_s3 <= 27'(frac_prod >> RATE_K);
		end
		if (v_s3)
			rate_s4 <= rneg_s1 ? -27'(rsum) : 27'(rsum);
		if (v_s4)
			prod_s5 <= rate_s4 * $signed({1'b0, time_step});
		if (v_s5)
			ang_q <= 33'(ang_old) + 33'(prod_rnd >>> GYRO_SHIFT);
	end

	assign acc_g    = acc_s1;
	assign rate_dps = rate_s4;
	assign ang_new  = ang_q;
	assign done     = done_q;
endmodule
`default_nettype wire

// ===== rtl/icaf_tilt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// tilt from gravity: bitwise square root, then CORDIC vectoring atan2
module icaf_tilt (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire icaf_pkg::accg_t num_y,
	input  wire icaf_pkg::accg_t side_u,
	input  wire icaf_pkg::accg_t vert_z,
	input  wire logic            flip_en,
	output icaf_pkg::ang_t       angle,
	output logic                 done
);
	import icaf_pkg::*;

	tilt_st_t st_q, st_nx;

	logic signed [SQRT_W-1:0] squ_s1;
	logic signed [SQRT_W-1:0] sqz_s1;
	accg_t                    y_q;
	logic                     flip_q;
	logic [SQRT_W-1:0]        v_q;
	logic [SQRT_W-1:0]        res_q;
	logic [SQRT_W-1:0]        bit_q;
	logic [STEP_W-1:0]        cnt_q;
	logic signed [CW-1:0]     x_q;
	logic signed [CW-1:0]     yr_q;
	logic signed [ZW-1:0]     z_q;
	logic                     zero_q;
	ang_t                     ang_q;
	logic                     done_q;

	logic [SQRT_W-1:0]        trial;
	logic signed [CW-1:0]     xs;
	logic signed [CW-1:0]     ys;
	logic signed [CW-1:0]     dx;
	logic signed [CW-1:0]     dy;
	logic signed [ZW-1:0]     z_rnd;

	always_comb begin
		st_nx = st_q;
		case (st_q)
			TP_IDLE:     if (start) st_nx = TP_SQ;
			TP_SQ:       st_nx = TP_SQRT;
			TP_SQRT:     if (cnt_q == STEP_W'(SQRT_STEPS - 1)) st_nx = TP_ROT_INIT;
			TP_ROT_INIT: st_nx = TP_ROT;
			TP_ROT:      if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) st_nx = TP_ROUND;
			TP_ROUND:    st_nx = TP_IDLE;
			default:     st_nx = TP_IDLE;
		endcase
	end

	always_comb begin
		trial = res_q + bit_q;
		xs    = flip_q ? -CW'(res_q[CW-2:0]) : CW'(res_q[CW-2:0]);
		ys    = CW'(y_q);
		dx    = yr_q >>> cnt_q;
		dy    = x_q >>> cnt_q;
		z_rnd = z_q + ZW'(ROT_RND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= TP_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_nx;
			done_q <= (st_q == TP_ROUND);
			if (st_q == TP_SQ || st_q == TP_ROT_INIT)
				cnt_q <= '0;
			else if (st_q == TP_SQRT || st_q == TP_ROT)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			TP_IDLE: begin
				if (start) begin
					squ_s1 <= side_u * side_u;
					sqz_s1 <= vert_z * vert_z;
					y_q    <= num_y;
					flip_q <= flip_en && vert_z[19];
				end
			end
			TP_SQ: begin
				v_q   <= SQRT_W'(squ_s1) + SQRT_W'(sqz_s1);
				res_q <= '0;
				bit_q <= SQRT_W'(1) << (SQRT_W - 2);
			end
			TP_SQRT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			TP_ROT_INIT: begin
				zero_q <= (xs == '0) && (ys == '0);
				if (xs < 0) begin
					z_q  <= (ys >= 0) ? ZW'(HALF_TURN) : -ZW'(HALF_TURN);
					x_q  <= -xs;
					yr_q <= -ys;
				end else begin
					z_q  <= '0;
					x_q  <= xs;
					yr_q <= ys;
				end
			end
			TP_ROT: begin
				if (yr_q > 0) begin
					x_q  <= x_q + dx;
					yr_q <= yr_q - dy;
					z_q  <= z_q + ZW'(ATAN_TAB[cnt_q]);
				end else begin
					x_q  <= x_q - dx;
					yr_q <= yr_q + dy;
					z_q  <= z_q - ZW'(ATAN_TAB[cnt_q]);
				end
			end
			TP_ROUND: begin
				ang_q <= zero_q ? '0 : 32'(z_rnd >>> ROT_SHIFT);
			end
			default: begin
			end
		endcase
	end

	assign angle = ang_q;
	assign done  = done_q;
endmodule
`default_nettype wire

// ===== rtl/imu_complementary_attitude_filter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// IMU attitude filter. One input word per raw sample: opcode plus seven signed sensor
// words and a Q1.15 time step. Calibration words (opcode 0) are absorbed and give
// no result; the word that completes a round then raises in_stall while the six
// offsets are formed (sums shifted down, truncated toward zero).
// Update words (opcode 1) give one result word: scaled acceleration, rate,
// temperature, the fused roll and pitch and the gyro-integrated yaw in Q16.16.
// An update takes no new word until its result is registered; the next word is
// taken the cycle after the result is registered. The update time is set by the
// two tilt units: 20 square-root steps then 20 CORDIC steps, running side by side;
// the three axis units (reciprocal scaling by 131072/131, gyro integration) and the
// temperature scaling finish earlier.
// in_stall is high whenever the block is busy. The result sits in an output
// register; while out_stall holds it, it does not change, and a finished update
// waits in the final state until the register frees up. A calibration word may be
// accepted while a result still waits.
// Reset (arst_n low) clears sums, offsets, angles and the handshakes; axis maps
// return to 1, 2, 3 and the gyro weight to 64225. wr_en writes a register at once
// and is to be used only while the block is idle; the block does not enforce it.
module imu_complementary_attitude_filter_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 opcode,
	input  wire icaf_pkg::raw_t       accel_x_raw,
	input  wire icaf_pkg::raw_t       accel_y_raw,
	input  wire icaf_pkg::raw_t       accel_z_raw,
	input  wire icaf_pkg::raw_t       temp_raw,
	input  wire icaf_pkg::raw_t       rate_x_raw,
	input  wire icaf_pkg::raw_t       rate_y_raw,
	input  wire icaf_pkg::raw_t       rate_z_raw,
	input  wire logic [15:0]          time_step,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output icaf_pkg::accg_t           accel_x_g,
	output icaf_pkg::accg_t           accel_y_g,
	output icaf_pkg::accg_t           accel_z_g,
	output icaf_pkg::rate_t           rate_x_dps,
	output icaf_pkg::rate_t           rate_y_dps,
	output icaf_pkg::rate_t           rate_z_dps,
	output icaf_pkg::temp_t           temperature,
	output icaf_pkg::ang_t            roll_deg,
	output icaf_pkg::ang_t            pitch_deg,
	output icaf_pkg::ang_t            yaw_deg,
	input  wire logic                 wr_en,
	input  wire logic [1:0]           wr_index,
	input  wire logic [16:0]          wr_data
);
	import icaf_pkg::*;

	top_st_t st_q, st_nx;

	// configuration
	logic signed [2:0] map_q [3];
	logic [16:0]       weight_q;
	logic [16:0]       wsat;

	// captured sample
	raw3_t       acc_raw_q;
	raw3_t       rate_raw_q;
	raw_t        temp_q;
	logic [15:0] ts_q;

	// calibration
	raw_t        cal_in [6];
	logic [26:0] sum_q [6];
	logic [16:0] cnt_q;
	logic [16:0] cnt_nx;
	logic        cal_full;
	logic signed [26:0] cal_adj [6];
	logic [15:0] cal_off [6];
	raw3_t       acc_off_q;
	raw3_t       rate_off_q;

	// work units
	logic        in_acc;
	logic        work_start_q;
	logic        tilt_start_q;
	accg_t       lane_acc [3];
	rate_t       lane_rate [3];
	ang_wide_t   lane_ng [3];
	logic [2:0]  lane_done;
	accg_t       acc_z1g;
	ang_t        tilt_ang [2];
	logic [1:0]  tilt_done;
	logic signed [16:0] tsum;
	logic        tneg;
	logic [15:0] tmag;
	logic        tdiv_done;
	logic [TDIV_QUO_W-1:0] tdiv_q;
	logic [5:0]  done_q;

	// merge
	ang_t               na [2];
	ang_t               aa_q [2];
	ang_t               fu_q [3];
	logic signed [33:0] dif_s2 [2];
	logic signed [51:0] prod_s3 [2];
	logic signed [51:0] prod_rnd [2];
	logic signed [33:0] smooth [2];

	// output register
	logic        out_load;
	logic        out_valid_q;
	accg_t       acc_o_q [3];
	rate_t       rate_o_q [3];
	temp_t       temp_o_q;
	ang_t        ang_o_q [3];

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		cal_in[0] = accel_x_raw;
		cal_in[1] = accel_y_raw;
		cal_in[2] = accel_z_raw;
		cal_in[3] = rate_x_raw;
		cal_in[4] = rate_y_raw;
		cal_in[5] = rate_z_raw;
		cnt_nx    = cnt_q + 17'd1;
		cal_full  = cnt_nx >= 17'(CALIB_SAMPLES);
		// offset = sum / count toward zero: bias negative sums before the shift
		for (int i = 0; i < 6; i++) begin
			cal_adj[i] = $signed(sum_q[i]) +
				$signed(sum_q[i][26] ? 27'(CALIB_SAMPLES - 1) : 27'd0);
			cal_off[i] = 16'(cal_adj[i] >>> CAL_SHIFT);
		end
		wsat      = (weight_q > 17'(WEIGHT_ONE)) ? 17'(WEIGHT_ONE) : weight_q;
		acc_z1g   = lane_acc[2] + 20'(ONE_G);
		tsum      = 17'(temp_q) + 17'(TEMP_BIAS);
		tneg      = tsum[16];
		tmag      = tneg ? 16'(-tsum) : 16'(tsum);
		na[0]     = tilt_ang[0];
		na[1]     = -tilt_ang[1];
		for (int i = 0; i < 2; i++) begin
			smooth[i]   = (34'(aa_q[i]) <<< 1) + 34'(aa_q[i]) + 34'(na[i]);
			prod_rnd[i] = prod_s3[i] + 52'sd32768;
		end
	end

	// sequencer
	always_comb begin
		st_nx    = st_q;
		out_load = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (op_t'(opcode) == OP_UPDATE)
						st_nx = ST_WORK;
					else if (cal_full)
						st_nx = ST_CAL;
				end
			end
			ST_CAL:    st_nx = ST_IDLE;
			ST_WORK:   if (&done_q) st_nx = ST_SMOOTH;
			ST_SMOOTH: st_nx = ST_DIFF;
			ST_DIFF:   st_nx = ST_MUL;
			ST_MUL:    st_nx = ST_BLEND;
			ST_BLEND:  st_nx = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					st_nx    = ST_IDLE;
				end
			end
			default:   st_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_nx;
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q[0] <= 3'sd1;
			map_q[1] <= 3'sd2;
			map_q[2] <= 3'sd3;
			weight_q <= 17'd64225;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_MAP_X:  map_q[0] <= wr_data[2:0];
				CFG_MAP_Y:  map_q[1] <= wr_data[2:0];
				CFG_MAP_Z:  map_q[2] <= wr_data[2:0];
				CFG_WEIGHT: weight_q <= wr_data;
				default: ;
			endcase
		end
	end

	// calibration sums, offsets, start strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				sum_q[i] <= '0;
			acc_off_q    <= '0;
			rate_off_q   <= '0;
			cnt_q        <= '0;
			work_start_q <= 1'b0;
			tilt_start_q <= 1'b0;
		end else begin
			work_start_q <= in_acc && (op_t'(opcode) == OP_UPDATE);
			tilt_start_q <= work_start_q;
			if (in_acc && op_t'(opcode) == OP_CAL) begin
				for (int i = 0; i < 6; i++)
					sum_q[i] <= sum_q[i] + 27'(cal_in[i]);
				cnt_q <= cnt_nx;
			end
			// round complete: take the offsets, start a fresh round
			if (st_q == ST_CAL) begin
				acc_off_q  <= {cal_off[2], cal_off[1], cal_off[0]};
				rate_off_q <= {cal_off[5], cal_off[4], cal_off[3]};
				for (int i = 0; i < 6; i++)
					sum_q[i] <= '0;
				cnt_q <= '0;
			end
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			acc_raw_q  <= {accel_z_raw, accel_y_raw, accel_x_raw};
			rate_raw_q <= {rate_z_raw, rate_y_raw, rate_x_raw};
			temp_q     <= temp_raw;
			ts_q       <= time_step;
		end
	end

	// three axis lanes
	for (genvar g = 0; g < 3; g++) begin : g_axis
		icaf_axis u_axis (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (work_start_q),
			.axis_map (map_q[g]),
			.acc_raw  (acc_raw_q),
			.rate_raw (rate_raw_q),
			.acc_off  (acc_off_q),
			.rate_off (rate_off_q),
			.time_step(ts_q),
			.ang_old  (fu_q[g]),
			.acc_g    (lane_acc[g]),
			.rate_dps (lane_rate[g]),
			.ang_new  (lane_ng[g]),
			.done     (lane_done[g])
		);
	end

	// roll: atan2(ay, +-|(az,ax)|), sign of az decides the half plane
	icaf_tilt u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tilt_start_q),
		.num_y  (lane_acc[1]),
		.side_u (lane_acc[0]),
		.vert_z (acc_z1g),
		.flip_en(1'b1),
		.angle  (tilt_ang[0]),
		.done   (tilt_done[0])
	);

	// pitch: -atan2(ax, |(az,ay)|), negated in the merge
	icaf_tilt u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tilt_start_q),
		.num_y  (lane_acc[0]),
		.side_u (lane_acc[1]),
		.vert_z (acc_z1g),
		.flip_en(1'b0),
		.angle  (tilt_ang[1]),
		.done   (tilt_done[1])
	);

	// temperature: (raw + bias) << frac / 340, toward zero
	icaf_sdiv u_temp_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (work_start_q),
		.numer (TDIV_NUM_W'(tmag) << TEMP_FRAC_BITS),
		.done  (tdiv_done),
		.quot  (tdiv_q)
	);

	// sticky completion flags, one per unit; cleared as the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= '0;
		else if (in_acc)
			done_q <= '0;
		else
			done_q <= done_q | {tdiv_done, tilt_done, lane_done};
	end

	// merge: smooth 3:1, then blend with the integrated gyro angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++)
				aa_q[i] <= '0;
			for (int i = 0; i < 3; i++)
				fu_q[i] <= '0;
		end else begin
			if (st_q == ST_SMOOTH)
				for (int i = 0; i < 2; i++)
					aa_q[i] <= 32'(smooth[i] >>> 2);
			if (st_q == ST_BLEND) begin
				for (int i = 0; i < 2; i++)
					fu_q[i] <= aa_q[i] + 32'(prod_rnd[i] >>> 16);
				fu_q[2] <= lane_ng[2][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			if (st_q == ST_DIFF)
				dif_s2[i] <= 34'(lane_ng[i]) - 34'(aa_q[i]);
			if (st_q == ST_MUL)
				prod_s3[i] <= dif_s2[i] * $signed({1'b0, wsat});
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			acc_o_q[0] <= lane_acc[0];
			acc_o_q[1] <= lane_acc[1];
			acc_o_q[2] <= acc_z1g;
			for (int i = 0; i < 3; i++) begin
				rate_o_q[i] <= lane_rate[i];
				ang_o_q[i]  <= fu_q[i];
			end
			temp_o_q <= tneg ? -25'(tdiv_q) : 25'(tdiv_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign accel_x_g   = acc_o_q[0];
	assign accel_y_g   = acc_o_q[1];
	assign accel_z_g   = acc_o_q[2];
	assign rate_x_dps  = rate_o_q[0];
	assign rate_y_dps  = rate_o_q[1];
	assign rate_z_dps  = rate_o_q[2];
	assign temperature = temp_o_q;
	assign roll_deg    = ang_o_q[0];
	assign pitch_deg   = ang_o_q[1];
	assign yaw_deg     = ang_o_q[2];
endmodule
`default_nettype wire

// ===== rtl/icaf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module icaf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        opcode,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] roll_deg
);
	// an update word keeps the block busy
	`ICAF_ASSERT_NXT(a_upd_busy, clk, arst_n, in_valid && !in_stall && opcode, in_stall)
	// a calibration word never raises a result
	`ICAF_ASSERT_NXT(a_cal_quiet, clk, arst_n, in_valid && !in_stall && !opcode && !out_valid, !out_valid)
	// results come out of the busy phase only
	`ICAF_ASSERT_NOW(a_out_src, clk, arst_n, $rose(out_valid), $past(in_stall))
	// stalled result word holds
	`ICAF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(roll_deg))
endmodule

bind imu_complementary_attitude_filter_top icaf_checker u_icaf_checker (.*);
`default_nettype wire
